/* rtl/core/rpt_pkg.sv */
// Package for the regex pattern tokenizer: item types, token and error codes, lexer modes.
`default_nettype none

package rpt_pkg;

    // Characters with a special role in a pattern
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_QUEST     = 8'h3F;

    typedef enum logic [3:0] {
        K_CONCAT = 4'd0,
        K_ALT    = 4'd1,
        K_STAR   = 4'd2,
        K_PLUS   = 4'd3,
        K_QUEST  = 4'd4,
        K_LIT    = 4'd5,
        K_ESC    = 4'd6,
        K_OPEN   = 4'd7,
        K_RANGE  = 4'd8,
        K_CLOSE  = 4'd9,
        K_DONE   = 4'd10,
        K_ERROR  = 4'd11
    } token_kind_t;

    typedef enum logic [2:0] {
        E_NONE       = 3'd0,
        E_BAD_ESCAPE = 3'd1,
        E_BAD_RANGE  = 3'd2,
        E_UNTERM     = 3'd3,
        E_LONE_DASH  = 3'd4
    } error_code_t;

    typedef enum logic [2:0] {
        M_OUT     = 3'd0,
        M_ESC_OUT = 3'd1,
        M_CSTART  = 3'd2,
        M_CLASS   = 3'd3,
        M_CESC    = 3'd4,
        M_DASH    = 3'd5,
        M_SKIP    = 3'd6
    } lexer_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       pattern_end;
    } in_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [7:0]  low_char;
        logic [7:0]  high_char;
        logic        negated;
        error_code_t error_code;
        logic        final_res;
    } out_item_t;

    // Kind of an alphanumeric: 1 digit, 2 lower case, 3 upper case, 0 none
    function automatic logic [1:0] alnum_kind(input logic [7:0] c);
        logic [1:0] k;
        k = 2'd0;
        if (c >= 8'h30 && c <= 8'h39) k = 2'd1;
        else if (c >= 8'h61 && c <= 8'h7A) k = 2'd2;
        else if (c >= 8'h41 && c <= 8'h5A) k = 2'd3;
        return k;
    endfunction

    // Characters allowed after a backslash inside a class
    function automatic logic is_class_escape(input logic [7:0] c);
        return (c == CH_BACKSLASH) || (c == CH_LBRACKET) || (c == CH_RBRACKET) ||
               (c == CH_BAR) || (c == CH_PLUS) || (c == CH_QUEST) || (c == CH_STAR);
    endfunction

    function automatic out_item_t make_token(input token_kind_t kind, input logic [7:0] lo,
                                             input logic [7:0] hi, input logic neg,
                                             input error_code_t err);
        out_item_t t;
        t.token_kind = kind;
        t.low_char   = lo;
        t.high_char  = hi;
        t.negated    = neg;
        t.error_code = err;
        t.final_res  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/regex_pattern_tokenizer.sv */
// Regex pattern tokenizer: one pattern character per item in, tokens out.
// Path: an accepted item waits in the input register until its tokens can be loaded into
// the token buffer, whose head slot is offered on the output port.
// Throughput: one item per cycle while each item gives at most one token and the sink
// is ready; an item giving several tokens holds off the next until its last token is taken.
// Reset: rst_n clears the lexer mode, class state and both handshake stages at once.
`default_nettype none

module regex_pattern_tokenizer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rpt_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rpt_pkg::out_item_t     out_item
);
    import rpt_pkg::*;

    // Input stage
    logic        stage_valid_reg;
    in_item_t    stage_reg;

    // Lexer state
    lexer_mode_t mode_reg, mode_next;
    logic        joinable_reg, joinable_next;
    logic        negated_reg, negated_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_low_reg, pend_low_next;
    logic [7:0]  pend_high_reg, pend_high_next;

    // Token buffer, slot 0 is the head
    out_item_t   slot_reg [3];
    logic [1:0]  cnt_reg;

    out_item_t   res [3];
    logic [1:0]  res_cnt;

    logic [7:0]  ch;
    logic        last;
    logic        range_ok;
    logic        pop;
    logic        load;

    assign ch       = stage_reg.ch;
    assign last     = stage_reg.pattern_end;
    assign range_ok = (alnum_kind(ch) != 2'd0) && (alnum_kind(ch) == alnum_kind(pend_low_reg))
                      && (pend_low_reg <= ch);

    assign pop       = out_valid && out_ready;
    assign load      = stage_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready));
    assign in_ready  = !stage_valid_reg || load;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot_reg[0];

    // Next lexer state
    always_comb
    begin
        mode_next       = mode_reg;
        joinable_next   = joinable_reg;
        negated_next    = negated_reg;
        pend_valid_next = pend_valid_reg;
        pend_low_next   = pend_low_reg;
        pend_high_next  = pend_high_reg;
        unique case (mode_reg) inside
            M_OUT:
            begin
                if (ch == CH_BAR)
                    joinable_next = 1'b0;
                else if (ch == CH_STAR || ch == CH_PLUS || ch == CH_QUEST)
                    joinable_next = 1'b1;
                else if (ch == CH_BACKSLASH)
                    mode_next = M_ESC_OUT;
                else if (ch == CH_LBRACKET)
                begin
                    negated_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    mode_next       = M_CSTART;
                end
                else
                    joinable_next = 1'b1;
            end
            M_ESC_OUT:
            begin
                joinable_next = 1'b1;
                mode_next     = M_OUT;
            end
            M_CSTART, M_CLASS:
            begin
                if (mode_reg == M_CSTART && ch == CH_CARET)
                begin
                    negated_next = 1'b1;
                    mode_next    = M_CLASS;
                end
                else if (ch == CH_DASH)
                    mode_next = pend_valid_reg ? M_DASH : M_SKIP;
                else if (ch == CH_BACKSLASH)
                    mode_next = M_CESC;
                else if (ch == CH_RBRACKET)
                begin
                    pend_valid_next = 1'b0;
                    negated_next    = 1'b0;
                    joinable_next   = 1'b1;
                    mode_next       = M_OUT;
                end
                else
                begin
                    pend_low_next   = ch;
                    pend_high_next  = ch;
                    pend_valid_next = 1'b1;
                    mode_next       = M_CLASS;
                end
            end
            M_CESC:
            begin
                if (is_class_escape(ch))
                begin
                    pend_low_next   = ch;
                    pend_high_next  = ch;
                    pend_valid_next = 1'b1;
                    mode_next       = M_CLASS;
                end
                else
                    mode_next = M_SKIP;
            end
            M_DASH:
            begin
                // absorb repeated dashes, widen the held element or fail
                if (ch != CH_DASH)
                begin
                    if (range_ok)
                    begin
                        pend_high_next = ch;
                        mode_next      = M_CLASS;
                    end
                    else
                        mode_next = M_SKIP;
                end
            end
            default:
            begin
            end
        endcase
        // Pattern end returns everything to reset
        if (last)
        begin
            mode_next       = M_OUT;
            joinable_next   = 1'b0;
            negated_next    = 1'b0;
            pend_valid_next = 1'b0;
            pend_low_next   = 8'd0;
            pend_high_next  = 8'd0;
        end
    end

    // Tokens caused by the staged item
    always_comb
    begin
        out_item_t   tok [3];
        logic [1:0]  n;
        lexer_mode_t mode_after;
        tok[0]     = make_token(K_CONCAT, 8'd0, 8'd0, 1'b0, E_NONE);
        tok[1]     = tok[0];
        tok[2]     = tok[0];
        n          = 2'd0;
        mode_after = mode_reg;
        unique case (mode_reg) inside
            M_OUT:
            begin
                mode_after = M_OUT;
                if (ch == CH_BAR)
                begin
                    tok[n] = make_token(K_ALT, 8'd0, 8'd0, 1'b0, E_NONE);
                    n = n + 2'd1;
                end
                else if (ch == CH_STAR || ch == CH_PLUS || ch == CH_QUEST)
                begin
                    tok[n] = make_token((ch == CH_STAR) ? K_STAR :
                                        ((ch == CH_PLUS) ? K_PLUS : K_QUEST),
                                        8'd0, 8'd0, 1'b0, E_NONE);
                    n = n + 2'd1;
                end
                else
                begin
                    if (joinable_reg)
                    begin
                        tok[n] = make_token(K_CONCAT, 8'd0, 8'd0, 1'b0, E_NONE);
                        n = n + 2'd1;
                    end
                    if (ch == CH_BACKSLASH)
                        mode_after = M_ESC_OUT;
                    else if (ch == CH_LBRACKET)
                    begin
                        tok[n] = make_token(K_OPEN, 8'd0, 8'd0, 1'b0, E_NONE);
                        n = n + 2'd1;
                        mode_after = M_CSTART;
                    end
                    else
                    begin
                        tok[n] = make_token(K_LIT, ch, ch, 1'b0, E_NONE);
                        n = n + 2'd1;
                    end
                end
            end
            M_ESC_OUT:
            begin
                tok[n] = make_token(K_ESC, ch, ch, 1'b0, E_NONE);
                n = n + 2'd1;
                mode_after = M_OUT;
            end
            M_CSTART, M_CLASS:
            begin
                if (mode_reg == M_CSTART && ch == CH_CARET)
                    mode_after = M_CLASS;
                else if (ch == CH_DASH)
                begin
                    if (!pend_valid_reg)
                    begin
                        tok[n] = make_token(K_ERROR, ch, ch, 1'b0, E_LONE_DASH);
                        n = n + 2'd1;
                        mode_after = M_SKIP;
                    end
                    else
                        mode_after = M_DASH;
                end
                else if (ch == CH_BACKSLASH)
                    mode_after = M_CESC;
                else
                begin
                    // flush the held element on a new element or the close
                    if (pend_valid_reg)
                    begin
                        tok[n] = make_token(K_RANGE, pend_low_reg, pend_high_reg, 1'b0, E_NONE);
                        n = n + 2'd1;
                    end
                    if (ch == CH_RBRACKET)
                    begin
                        tok[n] = make_token(K_CLOSE, 8'd0, 8'd0, negated_reg, E_NONE);
                        n = n + 2'd1;
                        mode_after = M_OUT;
                    end
                    else
                        mode_after = M_CLASS;
                end
            end
            M_CESC:
            begin
                if (is_class_escape(ch))
                begin
                    if (pend_valid_reg)
                    begin
                        tok[n] = make_token(K_RANGE, pend_low_reg, pend_high_reg, 1'b0, E_NONE);
                        n = n + 2'd1;
                    end
                    mode_after = M_CLASS;
                end
                else
                begin
                    tok[n] = make_token(K_ERROR, ch, ch, 1'b0, E_BAD_ESCAPE);
                    n = n + 2'd1;
                    mode_after = M_SKIP;
                end
            end
            M_DASH:
            begin
                if (ch != CH_DASH)
                begin
                    if (range_ok)
                        mode_after = M_CLASS;
                    else
                    begin
                        tok[n] = make_token(K_ERROR, ch, ch, 1'b0, E_BAD_RANGE);
                        n = n + 2'd1;
                        mode_after = M_SKIP;
                    end
                end
            end
            default:
                mode_after = M_SKIP;
        endcase
        // Close the pattern: done outside brackets, unterminated inside a class or an escape, nothing after an error
        if (last)
        begin
            if (mode_after == M_OUT)
            begin
                tok[n] = make_token(K_DONE, 8'd0, 8'd0, 1'b0, E_NONE);
                n = n + 2'd1;
            end
            else if (mode_after != M_SKIP)
            begin
                tok[n] = make_token(K_ERROR, ch, ch, 1'b0, E_UNTERM);
                n = n + 2'd1;
            end
        end
        // Mark the last token of the item
        if (n != 2'd0)
            tok[n - 2'd1].final_res = 1'b1;
        res     = tok;
        res_cnt = n;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            stage_valid_reg <= 1'b1;
        else if (load)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_reg <= in_item;
    end

    // Lexer state advances when the staged item moves into the buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_OUT;
            joinable_reg   <= 1'b0;
            negated_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_low_reg   <= 8'd0;
            pend_high_reg  <= 8'd0;
        end
        else if (load)
        begin
            mode_reg       <= mode_next;
            joinable_reg   <= joinable_next;
            negated_reg    <= negated_next;
            pend_valid_reg <= pend_valid_next;
            pend_low_reg   <= pend_low_next;
            pend_high_reg  <= pend_high_next;
        end
    end

    // Token buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res_cnt;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // Token buffer slots: load a fresh list or shift down on a pop
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= res;
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rpt_checker.sv */
// Port-level checks for the regex pattern tokenizer, bound to the top level.
`default_nettype none

module rpt_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire rpt_pkg::out_item_t out_item
);
    import rpt_pkg::*;

    // A waiting item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // Done always closes the tokens of its item
    a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind == K_DONE) |-> out_item.final_res)
        else $error("done token not marked final");

    // An error code appears on error tokens only
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind != K_ERROR) |-> (out_item.error_code == E_NONE))
        else $error("error code on non-error token");

    // A class range never runs backwards
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind == K_RANGE) |-> (out_item.low_char <= out_item.high_char))
        else $error("class range with low above high");

endmodule

bind regex_pattern_tokenizer rpt_checker u_rpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

/* bench/regex_pattern_tokenizer_tb.sv */
// Testbench for the regex pattern tokenizer: directed and random patterns checked against a predictor.

module regex_pattern_tokenizer_tb;

    import rpt_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       typed;
        out_item_t  want;
    } stim_row_t;

    localparam out_item_t NO_TOKEN = '{K_CONCAT, 8'h00, 8'h00, 1'b0, E_NONE, 1'b0};

    localparam logic [7:0] CLASS_ESCAPES [7] = '{CH_BACKSLASH, CH_LBRACKET, CH_RBRACKET,
                                                 CH_BAR, CH_PLUS, CH_QUEST, CH_STAR};

    localparam int DIRECTED_LEN = 31;

    // Directed patterns; rows with a typed token give exactly that one token
    localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
        '{8'h00,        1'b0, 1'b1, '{K_LIT, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{8'hFF,        1'b0, 1'b0, NO_TOKEN},
        '{CH_BAR,       1'b0, 1'b1, '{K_ALT, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_STAR,      1'b0, 1'b1, '{K_STAR, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_PLUS,      1'b0, 1'b1, '{K_PLUS, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_QUEST,     1'b0, 1'b1, '{K_QUEST, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_BACKSLASH, 1'b0, 1'b0, NO_TOKEN},
        '{8'hFF,        1'b0, 1'b1, '{K_ESC, 8'hFF, 8'hFF, 1'b0, E_NONE, 1'b1}},
        // class a-c--e then escaped ']' and close, ending the pattern
        '{CH_LBRACKET,  1'b0, 1'b0, NO_TOKEN},
        '{8'h61,        1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b0, 1'b0, NO_TOKEN},
        '{8'h63,        1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b0, 1'b0, NO_TOKEN},
        '{8'h65,        1'b0, 1'b0, NO_TOKEN},
        '{CH_BACKSLASH, 1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACKET,  1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACKET,  1'b1, 1'b0, NO_TOKEN},
        // empty negated class, then a dash with nothing before it
        '{CH_LBRACKET,  1'b0, 1'b1, '{K_OPEN, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_CARET,     1'b0, 1'b0, NO_TOKEN},
        '{CH_RBRACKET,  1'b0, 1'b1, '{K_CLOSE, 8'h00, 8'h00, 1'b1, E_NONE, 1'b1}},
        '{CH_LBRACKET,  1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b1, 1'b1, '{K_ERROR, CH_DASH, CH_DASH, 1'b0, E_LONE_DASH, 1'b1}},
        // descending range z-a
        '{CH_LBRACKET,  1'b0, 1'b1, '{K_OPEN, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{8'h7A,        1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b0, 1'b0, NO_TOKEN},
        '{8'h61,        1'b1, 1'b1, '{K_ERROR, 8'h61, 8'h61, 1'b0, E_BAD_RANGE, 1'b1}},
        // escaped dash inside a class
        '{CH_LBRACKET,  1'b0, 1'b1, '{K_OPEN, 8'h00, 8'h00, 1'b0, E_NONE, 1'b1}},
        '{CH_BACKSLASH, 1'b0, 1'b0, NO_TOKEN},
        '{CH_DASH,      1'b1, 1'b1, '{K_ERROR, CH_DASH, CH_DASH, 1'b0, E_BAD_ESCAPE, 1'b1}},
        // class left open at the end of the pattern
        '{CH_LBRACKET,  1'b1, 1'b0, NO_TOKEN}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic no_idle     = 1'b0;
    logic pressure_go = 1'b0;
    logic hold_sink   = 1'b0;

    int mismatches = 0;
    int live_chars = 0;

    out_item_t  expected_tokens [$];
    out_item_t  step_tokens [$];
    logic [7:0] pattern_q [$];

    // Predictor state
    lexer_mode_t mode;
    logic        joinable;
    logic        neg_class;
    logic        held_valid;
    logic [7:0]  held_lo;
    logic [7:0]  held_hi;

    regex_pattern_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [1:0] alnum_group(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 2'd1;
        if (c >= 8'h61 && c <= 8'h7A)
            return 2'd2;
        if (c >= 8'h41 && c <= 8'h5A)
            return 2'd3;
        return 2'd0;
    endfunction

    task automatic clear_state();
        mode       = M_OUT;
        joinable   = 1'b0;
        neg_class  = 1'b0;
        held_valid = 1'b0;
        held_lo    = 8'h00;
        held_hi    = 8'h00;
    endtask

    task automatic put_token(input token_kind_t kind, input logic [7:0] lo,
                             input logic [7:0] hi, input logic neg, input error_code_t err);
        out_item_t t;
        t.token_kind = kind;
        t.low_char   = lo;
        t.high_char  = hi;
        t.negated    = neg;
        t.error_code = err;
        t.final_res  = 1'b0;
        if (step_tokens.size() < 3)
            step_tokens = {step_tokens, t};
    endtask

    task automatic raise_error(input logic [7:0] c, input error_code_t err);
        put_token(K_ERROR, c, c, 1'b0, err);
        mode = M_SKIP;
    endtask

    // Flush the held element as a range and hold the new one
    task automatic hold_element(input logic [7:0] c);
        if (held_valid)
            put_token(K_RANGE, held_lo, held_hi, 1'b0, E_NONE);
        held_lo    = c;
        held_hi    = c;
        held_valid = 1'b1;
        mode       = M_CLASS;
    endtask

    task automatic class_char(input logic [7:0] c);
        if (c == CH_DASH)
        begin
            if (!held_valid)
                raise_error(c, E_LONE_DASH);
            else
                mode = M_DASH;
        end
        else if (c == CH_BACKSLASH)
            mode = M_CESC;
        else if (c == CH_RBRACKET)
        begin
            if (held_valid)
                put_token(K_RANGE, held_lo, held_hi, 1'b0, E_NONE);
            put_token(K_CLOSE, 8'h00, 8'h00, neg_class, E_NONE);
            held_valid = 1'b0;
            neg_class  = 1'b0;
            joinable   = 1'b1;
            mode       = M_OUT;
        end
        else
            hold_element(c);
    endtask

    // Work out the tokens caused by one pattern character
    task automatic predict_char(input logic [7:0] c, input logic is_end);
        step_tokens.delete();
        case (mode)
            M_OUT:
            begin
                if (c == CH_BAR)
                begin
                    put_token(K_ALT, 8'h00, 8'h00, 1'b0, E_NONE);
                    joinable = 1'b0;
                end
                else if (c == CH_STAR || c == CH_PLUS || c == CH_QUEST)
                begin
                    put_token(c == CH_STAR ? K_STAR : (c == CH_PLUS ? K_PLUS : K_QUEST),
                              8'h00, 8'h00, 1'b0, E_NONE);
                    joinable = 1'b1;
                end
                else
                begin
                    if (joinable)
                        put_token(K_CONCAT, 8'h00, 8'h00, 1'b0, E_NONE);
                    if (c == CH_BACKSLASH)
                        mode = M_ESC_OUT;
                    else if (c == CH_LBRACKET)
                    begin
                        put_token(K_OPEN, 8'h00, 8'h00, 1'b0, E_NONE);
                        neg_class  = 1'b0;
                        held_valid = 1'b0;
                        mode       = M_CSTART;
                    end
                    else
                    begin
                        put_token(K_LIT, c, c, 1'b0, E_NONE);
                        joinable = 1'b1;
                    end
                end
            end
            M_ESC_OUT:
            begin
                put_token(K_ESC, c, c, 1'b0, E_NONE);
                joinable = 1'b1;
                mode     = M_OUT;
            end
            M_CSTART:
            begin
                if (c == CH_CARET)
                begin
                    neg_class = 1'b1;
                    mode      = M_CLASS;
                end
                else
                    class_char(c);
            end
            M_CLASS:
                class_char(c);
            M_CESC:
            begin
                if (c == CH_BACKSLASH || c == CH_LBRACKET || c == CH_RBRACKET || c == CH_BAR ||
                    c == CH_PLUS || c == CH_QUEST || c == CH_STAR)
                    hold_element(c);
                else
                    raise_error(c, E_BAD_ESCAPE);
            end
            M_DASH:
            begin
                // Absorb repeated dashes; otherwise widen the held range or fail
                if (c != CH_DASH)
                begin
                    if (alnum_group(c) != 2'd0 && alnum_group(c) == alnum_group(held_lo) &&
                        held_lo <= c)
                    begin
                        held_hi = c;
                        mode    = M_CLASS;
                    end
                    else
                        raise_error(c, E_BAD_RANGE);
                end
            end
            default:
            begin
            end
        endcase
        if (is_end)
        begin
            if (mode == M_OUT)
                put_token(K_DONE, 8'h00, 8'h00, 1'b0, E_NONE);
            else if (mode != M_SKIP)
                put_token(K_ERROR, c, c, 1'b0, E_UNTERM);
            clear_state();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].final_res = 1'b1;
    endtask

    // Offer one character, wait for it to be taken, then record its tokens
    task automatic offer_char(input logic [7:0] c, input logic is_end, input logic typed,
                              input out_item_t want);
        while (!no_idle && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{ch: c, pattern_end: is_end};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (mode != M_SKIP)
            live_chars++;
        predict_char(c, is_end);
        if (typed)
            expected_tokens = {expected_tokens, want};
        else
            expected_tokens = {expected_tokens, step_tokens};
    endtask

    // Append one character to the pattern being built
    task automatic add_char(input logic [7:0] c);
        pattern_q = {pattern_q, c};
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_BAR || c == CH_STAR || c == CH_PLUS || c == CH_QUEST ||
            c == CH_BACKSLASH || c == CH_LBRACKET || c == CH_RBRACKET || c == CH_DASH)
            c = 8'h61 + c[3:0];
        return c;
    endfunction

    // Random alphanumeric of the given group, not below floor
    function automatic logic [7:0] rand_alnum(input int grp, input logic [7:0] floor);
        logic [7:0] base;
        logic [7:0] top;
        case (grp)
            1:       begin base = 8'h30; top = 8'h39; end
            2:       begin base = 8'h61; top = 8'h7A; end
            default: begin base = 8'h41; top = 8'h5A; end
        endcase
        if (floor < base)
            floor = base;
        return 8'($urandom_range(top, floor));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Sink: stall at random, except in the steady stretch or during a hold
    always @(posedge clk)
        out_ready <= hold_sink ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 30);

    // Hold the sink off long enough to back the block up
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_sink <= 1'b1;
        repeat (80) @(posedge clk);
        hold_sink <= 1'b0;
    end

    // Compare each token taken with the oldest expectation
    always @(posedge clk)
    begin : token_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("token_kind: expected none, got %0d", out_item.token_kind);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 8'(want.token_kind), 8'(out_item.token_kind));
                check_field("low_char", want.low_char, out_item.low_char);
                check_field("high_char", want.high_char, out_item.high_char);
                check_field("negated", 8'(want.negated), 8'(out_item.negated));
                check_field("error_code", 8'(want.error_code), 8'(out_item.error_code));
                check_field("final_res", 8'(want.final_res), 8'(out_item.final_res));
            end
        end
    end

    initial
    begin
        int         pattern_no;
        int         r;
        int         grp;
        int         n;
        logic [7:0] lo;
        logic [7:0] hi;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        clear_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            offer_char(DIRECTED[i].ch, DIRECTED[i].is_end, DIRECTED[i].typed, DIRECTED[i].want);

        // Random patterns, mostly well formed with random content
        live_chars = 0;
        pattern_no = 0;
        while (live_chars < 190)
        begin
            if (pattern_no == 12)
            begin
                no_idle     <= 1'b1;
                pressure_go <= 1'b1;
            end
            else if (pattern_no == 24)
                no_idle <= 1'b0;

            pattern_q.delete();
            repeat ($urandom_range(1, 6))
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    add_char(plain_char());
                else if (r < 40)
                begin
                    grp = $urandom_range(0, 2);
                    add_char(grp == 0 ? CH_STAR : (grp == 1 ? CH_PLUS : CH_QUEST));
                end
                else if (r < 48)
                    add_char(CH_BAR);
                else if (r < 58)
                begin
                    add_char(CH_BACKSLASH);
                    add_char(8'($urandom_range(0, 255)));
                end
                else if (r < 88)
                begin
                    add_char(CH_LBRACKET);
                    if ($urandom_range(0, 99) < 30)
                        add_char(CH_CARET);
                    n = $urandom_range(0, 4);
                    repeat (n)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 35)
                            add_char(plain_char());
                        else if (r < 60)
                        begin
                            add_char(CH_BACKSLASH);
                            add_char(CLASS_ESCAPES[$urandom_range(0, 6)]);
                        end
                        else if (r < 95)
                        begin
                            grp = $urandom_range(1, 3);
                            lo  = rand_alnum(grp, 8'h00);
                            hi  = rand_alnum(grp, lo);
                            add_char(lo);
                            add_char(CH_DASH);
                            if ($urandom_range(0, 99) < 20)
                                add_char(CH_DASH);
                            add_char(hi);
                            if ($urandom_range(0, 99) < 20)
                            begin
                                add_char(CH_DASH);
                                add_char(rand_alnum(grp, hi));
                            end
                        end
                        else
                            add_char(8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 99) < 92)
                        add_char(CH_RBRACKET);
                end
                else
                    add_char(8'($urandom_range(0, 255)));
            end
            // Now and then leave an escape open at the end
            if ($urandom_range(0, 99) < 6)
                add_char(CH_BACKSLASH);

            foreach (pattern_q[i])
                offer_char(pattern_q[i], i == pattern_q.size() - 1, 1'b0, NO_TOKEN);
            pattern_no++;
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for stray tokens
        for (n = 0; n < 20000 && expected_tokens.size() != 0; n++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
